[src/srmq_pkg.sv]
// ----------------------------------------------------------------------------
// srmq_pkg
// Shared types and constants for the sparse table range-minimum engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srmq_pkg;

  // Port field widths
  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 16;
  localparam int TAG_W    = 16;
  localparam int POS_W    = 15;
  localparam int STATUS_W = 2;

  // Request opcodes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_BUILT = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD_L0,
    S_BUILD_LK,
    S_BUILD_DRAIN,
    S_QRY_WAIT,
    S_QRY_PICK,
    S_QRY_ELEM,
    S_RESP
  } state_e;

  // Element store control
  typedef struct packed {
    logic append;
    logic clear;
  } elem_ctrl_t;

endpackage

`default_nettype wire

[src/srmq_elem_store.sv]
// ----------------------------------------------------------------------------
// srmq_elem_store
// Element memory holding (value, tag) pairs plus the element count.
// One append write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srmq_elem_store #(
  parameter int  MAX_LEN = 32768,
  parameter int  VW      = 16,
  parameter int  TW      = 16,
  localparam int PW      = $clog2(MAX_LEN),
  localparam int CW      = $clog2(MAX_LEN + 1)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  srmq_pkg::elem_ctrl_t     ctrl_i,
  input  wire  [VW-1:0]            wr_value_i,
  input  wire  [TW-1:0]            wr_tag_i,
  input  wire                      rd_en_i,
  input  wire  [PW-1:0]            rd_addr_i,
  output logic [VW-1:0]            rd_value_o,
  output logic [TW-1:0]            rd_tag_o,
  output logic [CW-1:0]            count_o,
  output logic                     full_o
);

  logic [VW+TW-1:0] mem [MAX_LEN];
  logic [VW+TW-1:0] rd_data_q;
  logic [CW-1:0]    count_q, count_d;

  // Count update: clear wins over append
  always_comb begin
    priority if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.append) begin
      count_d = count_q + CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Memory: append at the current count, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.append) begin
      mem[count_q[PW-1:0]] <= {wr_value_i, wr_tag_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_value_o = rd_data_q[VW+TW-1:TW];
  assign rd_tag_o   = rd_data_q[TW-1:0];
  assign count_o    = count_q;
  assign full_o     = (count_q == CW'(MAX_LEN));

endmodule

`default_nettype wire

[src/srmq_level_calc.sv]
// ----------------------------------------------------------------------------
// srmq_level_calc
// Query front end: orders the two positions, finds the table level that
// covers the range and the end index of the lower window. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module srmq_level_calc #(
  parameter int  MAX_LEN = 32768,
  parameter int  LEVELS  = 16,
  localparam int PW      = $clog2(MAX_LEN),
  localparam int CW      = $clog2(MAX_LEN + 1),
  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire  [PW-1:0]      pos_a_i,
  input  wire  [PW-1:0]      pos_b_i,
  output logic               valid_o,
  output logic [LW-1:0]      level_o,
  output logic [PW-1:0]      idx_a_o,
  output logic [PW-1:0]      idx_b_o
);

  logic              va_q, vb_q, vc_q;
  logic [PW-1:0]     lo_d, hi_d, lo_a_q, hi_a_q, lo_b_q, hi_b_q;
  logic [CW-1:0]     len_d, len_q;
  logic [LEVELS-1:0] ge;
  logic [LW-1:0]     level_d, level_q;
  logic [PW-1:0]     idx_a_d, idx_a_q, idx_b_q;

  // Stage A: order the ends, range length
  always_comb begin
    if (pos_a_i > pos_b_i) begin
      lo_d = pos_b_i;
      hi_d = pos_a_i;
    end else begin
      lo_d = pos_a_i;
      hi_d = pos_b_i;
    end
    len_d = CW'(hi_d) - CW'(lo_d) + CW'(1);
  end

  // Stage B: level = floor(log2(len)), clamped to the top level
  always_comb begin
    ge    = '0;
    ge[0] = 1'b1;
    for (int i = 1; i < LEVELS; i++) begin
      ge[i] = (32'(len_q) >= (32'd1 << i));
    end
    level_d = LW'($countones(ge) - 1);
  end

  // Stage C: end index of the window starting at the lower position
  assign idx_a_d = PW'(CW'(lo_b_q) + (CW'(1) << level_q) - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= start_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_a_q <= lo_d;
      hi_a_q <= hi_d;
      len_q  <= len_d;
    end
    if (va_q) begin
      lo_b_q  <= lo_a_q;
      hi_b_q  <= hi_a_q;
      level_q <= level_d;
    end
    if (vb_q) begin
      idx_a_q <= idx_a_d;
      idx_b_q <= hi_b_q;
    end
  end

  assign valid_o = vc_q;
  assign level_o = level_q;
  assign idx_a_o = idx_a_q;
  assign idx_b_o = idx_b_q;

endmodule

`default_nettype wire

[src/srmq_table.sv]
// ----------------------------------------------------------------------------
// srmq_table
// Sparse table memory. Each entry holds an argmin position and its value.
// Two registered read ports, one write port, and the argmin pick between
// the two read entries (first only if strictly smaller).
// ----------------------------------------------------------------------------
`default_nettype none

module srmq_table #(
  parameter int  MAX_LEN = 32768,
  parameter int  LEVELS  = 16,
  parameter int  VW      = 16,
  localparam int PW      = $clog2(MAX_LEN),
  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int AW      = $clog2(LEVELS * MAX_LEN),
  localparam int EW      = PW + VW
) (
  input  wire                clk_i,
  input  wire                rd_en_i,
  input  wire  [LW-1:0]      rd_lvl_i,
  input  wire  [PW-1:0]      rd_idx_a_i,
  input  wire  [PW-1:0]      rd_idx_b_i,
  input  wire                wr_en_i,
  input  wire  [LW-1:0]      wr_lvl_i,
  input  wire  [PW-1:0]      wr_idx_i,
  input  wire  [PW-1:0]      wr_pos_i,
  input  wire  [VW-1:0]      wr_val_i,
  output logic [PW-1:0]      win_pos_o,
  output logic [VW-1:0]      win_val_o
);

  logic [EW-1:0] mem [LEVELS * MAX_LEN];
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] addr_a, addr_b, addr_w;
  logic          a_smaller;

  // Flat address: level-major rows of MAX_LEN entries
  function automatic logic [AW-1:0] tbl_addr(input logic [LW-1:0] lvl,
                                             input logic [PW-1:0] idx);
    return AW'(lvl) * AW'(MAX_LEN) + AW'(idx);
  endfunction

  assign addr_a = tbl_addr(rd_lvl_i, rd_idx_a_i);
  assign addr_b = tbl_addr(rd_lvl_i, rd_idx_b_i);
  assign addr_w = tbl_addr(wr_lvl_i, wr_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_w] <= {wr_pos_i, wr_val_i};
    end
    if (rd_en_i) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  // Ties go to the second (right) entry
  assign a_smaller = (rd_a_q[VW-1:0] < rd_b_q[VW-1:0]);
  assign win_pos_o = a_smaller ? rd_a_q[EW-1:VW] : rd_b_q[EW-1:VW];
  assign win_val_o = a_smaller ? rd_a_q[VW-1:0]  : rd_b_q[VW-1:0];

endmodule

`default_nettype wire

[src/sparse_table_range_min_query.sv]
// Append, clear and rejected requests: result goes straight to the result register.
// Query: 3-stage level calc, table read, element read, result register. No request
// is accepted until the last result reaches the output register; a stalled result
// blocks the next request. Build over n elements fills L = min(floor(log2 n)+1,
// LEVELS) levels, one table entry per cycle within a level through the table write port.
// Reset clears the element count and the built flag; memories are not cleared.
// ----------------------------------------------------------------------------
// sparse_table_range_min_query
// Range-minimum engine on a sparse table held in synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_min_query #(
  parameter int MAX_LEN    = 32768,
  parameter int LEVELS     = 16,
  parameter int VALUE_BITS = 16,
  parameter int TAG_BITS   = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [srmq_pkg::REQ_W-1:0]         req_type_i,
  input  wire  [srmq_pkg::VALUE_W-1:0]       value_i,
  input  wire  [srmq_pkg::TAG_W-1:0]         tag_i,
  input  wire  [srmq_pkg::POS_W-1:0]         left_pos_i,
  input  wire  [srmq_pkg::POS_W-1:0]         right_pos_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [srmq_pkg::STATUS_W-1:0]      status_o,
  output logic [srmq_pkg::POS_W-1:0]         position_o,
  output logic [srmq_pkg::VALUE_W-1:0]       min_value_o,
  output logic [srmq_pkg::TAG_W-1:0]         min_tag_o
);

  localparam int PW   = $clog2(MAX_LEN);
  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VW   = (VALUE_BITS < srmq_pkg::VALUE_W) ? VALUE_BITS : srmq_pkg::VALUE_W;
  localparam int TW   = (TAG_BITS < srmq_pkg::TAG_W) ? TAG_BITS : srmq_pkg::TAG_W;
  localparam int CMPW = (CW > srmq_pkg::POS_W) ? CW : srmq_pkg::POS_W;

  srmq_pkg::state_e  state_q, state_d;
  srmq_pkg::req_e    req;
  srmq_pkg::status_e res_status_q, res_status_d, out_status_q;

  logic                         in_accept;
  logic                         built_q, built_d;
  logic [PW-1:0]                bld_idx_q, bld_idx_d;
  logic [LW-1:0]                bld_lvl_q, bld_lvl_d;
  logic [CW-1:0]                bld_width_q, bld_width_d;
  logic [CW:0]                  width_x2;
  logic [CW-1:0]                idx_next;
  logic                         last_idx, next_level_ok, out_of_range;
  logic                         wpipe_v_q, wpipe_v_d;
  logic [PW-1:0]                wpipe_idx_q, wpipe_idx_d;
  logic [srmq_pkg::POS_W-1:0]   res_pos_q, res_pos_d, out_pos_q;
  logic [srmq_pkg::VALUE_W-1:0] res_val_q, res_val_d, out_val_q;
  logic [srmq_pkg::TAG_W-1:0]   res_tag_q, res_tag_d, out_tag_q;
  logic                         out_valid_q, out_valid_d, out_load;

  // Element store signals
  srmq_pkg::elem_ctrl_t elem_ctrl;
  logic                 elem_rd_en;
  logic [PW-1:0]        elem_rd_addr;
  logic [VW-1:0]        elem_value;
  logic [TW-1:0]        elem_tag;
  logic [CW-1:0]        count;
  logic                 full;

  // Table signals
  logic          tbl_rd_en, tbl_wr_en, lvl0;
  logic [LW-1:0] tbl_rd_lvl;
  logic [PW-1:0] tbl_idx_a, tbl_idx_b, tbl_wr_pos, win_pos;
  logic [VW-1:0] tbl_wr_val, win_val;

  // Level calc signals
  logic          lc_start, lc_valid;
  logic [LW-1:0] lc_level;
  logic [PW-1:0] lc_idx_a, lc_idx_b;

  srmq_elem_store #(
    .MAX_LEN (MAX_LEN),
    .VW      (VW),
    .TW      (TW)
  ) u_elem_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (elem_ctrl),
    .wr_value_i (value_i[VW-1:0]),
    .wr_tag_i   (tag_i[TW-1:0]),
    .rd_en_i    (elem_rd_en),
    .rd_addr_i  (elem_rd_addr),
    .rd_value_o (elem_value),
    .rd_tag_o   (elem_tag),
    .count_o    (count),
    .full_o     (full)
  );

  srmq_level_calc #(
    .MAX_LEN (MAX_LEN),
    .LEVELS  (LEVELS)
  ) u_level_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lc_start),
    .pos_a_i (PW'(left_pos_i)),
    .pos_b_i (PW'(right_pos_i)),
    .valid_o (lc_valid),
    .level_o (lc_level),
    .idx_a_o (lc_idx_a),
    .idx_b_o (lc_idx_b)
  );

  srmq_table #(
    .MAX_LEN (MAX_LEN),
    .LEVELS  (LEVELS),
    .VW      (VW)
  ) u_table (
    .clk_i      (clk_i),
    .rd_en_i    (tbl_rd_en),
    .rd_lvl_i   (tbl_rd_lvl),
    .rd_idx_a_i (tbl_idx_a),
    .rd_idx_b_i (tbl_idx_b),
    .wr_en_i    (tbl_wr_en),
    .wr_lvl_i   (bld_lvl_q),
    .wr_idx_i   (wpipe_idx_q),
    .wr_pos_i   (tbl_wr_pos),
    .wr_val_i   (tbl_wr_val),
    .win_pos_o  (win_pos),
    .win_val_o  (win_val)
  );

  // Request handshake
  assign in_stall_o = (state_q != srmq_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign req        = srmq_pkg::req_e'(req_type_i);

  // Range check against the current element count
  assign out_of_range = (CMPW'(left_pos_i) >= CMPW'(count)) ||
                        (CMPW'(right_pos_i) >= CMPW'(count));

  // Build walk bookkeeping
  assign idx_next      = CW'(bld_idx_q) + CW'(1);
  assign last_idx      = (idx_next == count);
  assign width_x2      = {bld_width_q, 1'b0};
  assign next_level_ok = (width_x2 <= (CW+1)'(count)) && ((32'(bld_lvl_q) + 1) < LEVELS);

  // Table write-back: level 0 takes its index as the position and the value from the
  // element store, higher levels take the pick of the two lower-level entries
  assign lvl0       = (bld_lvl_q == '0);
  assign tbl_wr_en  = wpipe_v_q;
  assign tbl_wr_pos = lvl0 ? wpipe_idx_q : win_pos;
  assign tbl_wr_val = lvl0 ? elem_value  : win_val;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    built_d      = built_q;
    bld_idx_d    = bld_idx_q;
    bld_lvl_d    = bld_lvl_q;
    bld_width_d  = bld_width_q;
    wpipe_v_d    = 1'b0;
    wpipe_idx_d  = wpipe_idx_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_val_d    = res_val_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_load     = 1'b0;
    elem_ctrl    = '0;
    elem_rd_en   = 1'b0;
    elem_rd_addr = bld_idx_q;
    tbl_rd_en    = 1'b0;
    tbl_rd_lvl   = lc_level;
    tbl_idx_a    = lc_idx_a;
    tbl_idx_b    = lc_idx_b;
    lc_start     = 1'b0;

    unique case (state_q)
      srmq_pkg::S_IDLE: begin
        if (in_accept) begin
          res_status_d = srmq_pkg::STATUS_OK;
          res_pos_d    = '0;
          res_val_d    = '0;
          res_tag_d    = '0;
          state_d      = srmq_pkg::S_RESP;
          unique case (req)
            srmq_pkg::REQ_APPEND: begin
              if (full) begin
                res_status_d = srmq_pkg::STATUS_FULL;
              end else begin
                elem_ctrl.append = 1'b1;
                res_pos_d        = srmq_pkg::POS_W'(count);
                built_d          = 1'b0;
              end
            end
            srmq_pkg::REQ_BUILD: begin
              if (count == '0) begin
                built_d = 1'b1;
              end else begin
                bld_idx_d   = '0;
                bld_lvl_d   = '0;
                bld_width_d = CW'(1);
                state_d     = srmq_pkg::S_BUILD_L0;
              end
            end
            srmq_pkg::REQ_QUERY: begin
              priority if (!built_q) begin
                res_status_d = srmq_pkg::STATUS_NOT_BUILT;
              end else if (out_of_range) begin
                res_status_d = srmq_pkg::STATUS_RANGE;
              end else begin
                lc_start = 1'b1;
                state_d  = srmq_pkg::S_QRY_WAIT;
              end
            end
            srmq_pkg::REQ_CLEAR: begin
              elem_ctrl.clear = 1'b1;
              built_d         = 1'b0;
            end
          endcase
        end
      end

      // Level 0: entry i is (i, value[i])
      srmq_pkg::S_BUILD_L0: begin
        elem_rd_en  = 1'b1;
        wpipe_v_d   = 1'b1;
        wpipe_idx_d = bld_idx_q;
        if (last_idx) begin
          state_d = srmq_pkg::S_BUILD_DRAIN;
        end else begin
          bld_idx_d = bld_idx_q + PW'(1);
        end
      end

      // Level k: pick of entries (k-1, i-half) and (k-1, i)
      srmq_pkg::S_BUILD_LK: begin
        tbl_rd_en   = 1'b1;
        tbl_rd_lvl  = bld_lvl_q - LW'(1);
        tbl_idx_a   = bld_idx_q - PW'(bld_width_q >> 1);
        tbl_idx_b   = bld_idx_q;
        wpipe_v_d   = 1'b1;
        wpipe_idx_d = bld_idx_q;
        if (last_idx) begin
          state_d = srmq_pkg::S_BUILD_DRAIN;
        end else begin
          bld_idx_d = bld_idx_q + PW'(1);
        end
      end

      // Last write of the level lands here before the next level reads it
      srmq_pkg::S_BUILD_DRAIN: begin
        if (next_level_ok) begin
          bld_lvl_d   = bld_lvl_q + LW'(1);
          bld_width_d = bld_width_q << 1;
          bld_idx_d   = PW'((bld_width_q << 1) - CW'(1));
          state_d     = srmq_pkg::S_BUILD_LK;
        end else begin
          built_d = 1'b1;
          state_d = srmq_pkg::S_RESP;
        end
      end

      srmq_pkg::S_QRY_WAIT: begin
        if (lc_valid) begin
          tbl_rd_en = 1'b1;
          state_d   = srmq_pkg::S_QRY_PICK;
        end
      end

      srmq_pkg::S_QRY_PICK: begin
        elem_rd_en   = 1'b1;
        elem_rd_addr = win_pos;
        state_d      = srmq_pkg::S_QRY_ELEM;
      end

      srmq_pkg::S_QRY_ELEM: begin
        res_pos_d = srmq_pkg::POS_W'(win_pos);
        res_val_d = srmq_pkg::VALUE_W'(elem_value);
        res_tag_d = srmq_pkg::TAG_W'(elem_tag);
        state_d   = srmq_pkg::S_RESP;
      end

      // Hand the result to the output register once it is free
      srmq_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = srmq_pkg::S_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srmq_pkg::S_IDLE;
      built_q     <= 1'b0;
      wpipe_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      wpipe_v_q   <= wpipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bld_idx_q    <= bld_idx_d;
    bld_lvl_q    <= bld_lvl_d;
    bld_width_q  <= bld_width_d;
    wpipe_idx_q  <= wpipe_idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_val_q    <= res_val_d;
    res_tag_q    <= res_tag_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_val_q    <= res_val_q;
      out_tag_q    <= res_tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;
  assign min_value_o = out_val_q;
  assign min_tag_o   = out_tag_q;

endmodule

`default_nettype wire
